/* rtl/lstl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the leap-second step table lookup.
// No dependencies; used by every RTL file of the block.
package lstl_pkg;

  localparam int ENTRY_MJD_W   = 17;
  localparam int OFF_W         = 8;
  localparam int IDX_W         = 6;
  localparam int JD_W          = 55;
  localparam int DAYLEN_W      = 17;
  localparam int CFG_W         = 7;
  localparam int CMD_W         = 2;
  localparam int IN_DATA_W     = 144;
  localparam int OUT_DATA_W    = 40;

  // Reduced-time difference is clamped to +/- 2**CLAMP_SHIFT LSBs of day fixed point
  localparam int CLAMP_SHIFT   = 45;
  localparam int CLAMP_W       = 47;
  localparam int PROD_W        = 64;

  localparam int SEC_PER_DAY   = 86400;
  // 2400000.5 days expressed in half days
  localparam logic [63:0] JD_BASE_HALF_DAYS = 64'd4800001;

  localparam int BUILTIN_STEPS = 28;
  localparam int BUILTIN_OFF0  = 10;
  localparam int CFG_RESET     = 28;

  localparam logic [ENTRY_MJD_W-1:0] BUILTIN_MJD [BUILTIN_STEPS] = '{
    17'd41317, 17'd41499, 17'd41683, 17'd42048, 17'd42413, 17'd42778, 17'd43144,
    17'd43509, 17'd43874, 17'd44239, 17'd44786, 17'd45151, 17'd45516, 17'd46247,
    17'd47161, 17'd47892, 17'd48257, 17'd48804, 17'd49169, 17'd49534, 17'd50083,
    17'd50630, 17'd51179, 17'd53736, 17'd54832, 17'd56109, 17'd57204, 17'd57754
  };

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_INDEX = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_OFF_UTC = 2'd1,
    CMD_OFF_TAI = 2'd2,
    CMD_DAY_UTC = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEARCH,
    ST_PREV,
    ST_PREVW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [ENTRY_MJD_W-1:0] mjd;
    logic signed [OFF_W-1:0] off;
  } entry_t;

  // Reset content of one table slot
  function automatic entry_t builtin_entry(input int unsigned i);
    entry_t e;
    e = '0;
    if (i < BUILTIN_STEPS) begin
      e.mjd = BUILTIN_MJD[i[4:0]];
      e.off = OFF_W'(BUILTIN_OFF0 + i);
    end
    return e;
  endfunction

endpackage

/* rtl/lstl_step_mem.sv */
`timescale 1ns / 1ps
// Step table storage: one write port, one registered read port, and the
// post-reset sweep that loads the built-in steps. Depends on lstl_pkg.
module lstl_step_mem
  import lstl_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  output logic                     init_busy,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  localparam int AW = $clog2(DEPTH);

  entry_t          mem [DEPTH];
  entry_t          rd_data_r;
  logic            init_r;
  logic [AW-1:0]   icnt_r;
  logic [AW-1:0]   icnt_nxt;
  logic            init_nxt;
  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;

  always_comb begin
    icnt_nxt = icnt_r;
    init_nxt = init_r;
    if (init_r) begin
      icnt_nxt = icnt_r + AW'(1);
      if (icnt_r == AW'(DEPTH - 1)) begin
        init_nxt = 1'b0;
      end
    end
  end

  // sweep owns the write port until every slot holds its reset value
  always_comb begin
    we    = init_r | wr_en;
    waddr = init_r ? icnt_r : wr_addr;
    wdata = init_r ? builtin_entry(32'(icnt_r)) : wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b1;
      icnt_r <= '0;
    end else begin
      init_r <= init_nxt;
      icnt_r <= icnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign init_busy = init_r;

endmodule

/* rtl/leap_second_table_lookup.sv */
`timescale 1ns / 1ps
// Top level of the TAI-UTC leap-second step table lookup.
// Depends on lstl_pkg and lstl_step_mem.
//
//  channel | dir | handshake           | contents
//  --------+-----+---------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready | tuser: cmd; tdata: load entry and JD parts
//  out_    | out | out_tvalid/tready   | tdata: offsets, day length, status
//  cfg_    | in  | cfg_wr_en           | cfg_wr_data: active entry count
//
// Flow: a load goes to ST_OUT and then into the output register; a query reads one slot
// per cycle of the N active entries (1..TABLE_DEPTH), newest first, through a three-stage
// compare pipe and stops at the first match; a day query whose step ends the day also
// reads the slot before it. Reset: after rst_n rises a sweep writes all TABLE_DEPTH slots
// and loads the built-in steps while in_tready stays low. Stalls: a waiting result holds the
// output register; one more transaction is accepted and holds in ST_OUT until it frees.
module leap_second_table_lookup
  import lstl_pkg::*;
#(
  parameter int TABLE_DEPTH       = 64,
  parameter int DAY_FRACTION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // [1:0] cmd
  input  logic [CMD_W-1:0]      in_tuser,
  // [5:0] entry_index, [22:6] entry_mjd, [30:23] entry_offset,
  // [85:31] jd_part1, [140:86] jd_part2, [143:141] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] offset_today, [15:8] offset_next_day, [32:16] day_length,
  // [33] status, [39:34] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int F     = DAY_FRACTION_BITS;
  // reduced MJD: sum of the two parts minus the epoch, signed
  localparam int MJD_W = ((JD_W + 1 > F + 23) ? JD_W + 1 : F + 23) + 1;
  // entry start in fixed point, as a signed value
  localparam int SW    = F + ENTRY_MJD_W + 1;
  localparam int DW    = ((MJD_W > SW) ? MJD_W : SW) + 1;

  localparam logic [MJD_W-1:0]     JD_BASE     = MJD_W'(JD_BASE_HALF_DAYS << (F - 1));
  localparam logic signed [DW-1:0] ONE_DAY     = DW'(1) << F;
  localparam logic signed [DW-1:0] NEG_ONE_DAY = -ONE_DAY;
  localparam logic signed [DW-1:0] CLAMP_POS   = DW'(1) << CLAMP_SHIFT;
  localparam logic signed [DW-1:0] CLAMP_NEG   = -CLAMP_POS;

  // ---------------------------------------------------------------- input fields
  logic [IDX_W-1:0]        f_index;
  logic [ENTRY_MJD_W-1:0]  f_mjd;
  logic [OFF_W-1:0]        f_off;
  logic [JD_W-1:0]         f_jd1;
  logic [JD_W-1:0]         f_jd2;
  cmd_t                    f_cmd;

  assign f_index = in_tdata[5:0];
  assign f_mjd   = in_tdata[22:6];
  assign f_off   = in_tdata[30:23];
  assign f_jd1   = in_tdata[85:31];
  assign f_jd2   = in_tdata[140:86];
  assign f_cmd   = cmd_t'(in_tuser);

  // ---------------------------------------------------------------- registers
  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        cfg_count_r;
  cmd_t                    cmd_r, cmd_nxt;
  logic signed [MJD_W-1:0] mjd_r, mjd_nxt;
  logic [AW-1:0]           ra_r, ra_nxt;
  logic                    issue_done_r, issue_done_nxt;

  // compare pipe: p0 = read data, p1 = difference, p2 = flags and product
  logic                    v0_r, v0_nxt;
  logic [AW-1:0]           idx0_r;
  logic                    v1_r, v1_nxt;
  logic [AW-1:0]           idx1_r;
  logic signed [OFF_W-1:0] off1_r;
  logic signed [DW-1:0]    d_r, d_nxt;
  logic                    v2_r, v2_nxt;
  logic [AW-1:0]           idx2_r;
  logic signed [OFF_W-1:0] off2_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                    utc_ge2_r, day_ge2_r, big_pos2_r, big_neg2_r;
  logic                    utc_ge_nxt, day_ge_nxt, big_pos_nxt, big_neg_nxt;

  logic signed [OFF_W-1:0] today_r, today_nxt;
  logic signed [OFF_W-1:0] next_r, next_nxt;
  logic                    status_r, status_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]        out_today_r, out_today_nxt;
  logic [OFF_W-1:0]        out_next_r, out_next_nxt;
  logic [DAYLEN_W-1:0]     out_daylen_r, out_daylen_nxt;
  logic                    out_status_r, out_status_nxt;

  // ---------------------------------------------------------------- memory
  logic                    init_busy;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  entry_t                  mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  entry_t                  rd_data;

  lstl_step_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_busy (init_busy),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_en     (mem_re),
    .rd_addr   (mem_raddr),
    .rd_data   (rd_data)
  );

  // ---------------------------------------------------------------- datapath
  logic [AW-1:0]           start_addr;
  logic signed [DW-1:0]    mjd_ext;
  logic [DW-1:0]           start_ext;
  logic signed [PROD_W-1:0] rhs;
  logic                    tai_ge;
  logic                    at_zero;
  logic                    hit;

  // reduce the query time to MJD in fixed point
  assign mjd_nxt = {{(MJD_W - JD_W){f_jd1[JD_W-1]}}, f_jd1}
                 + {{(MJD_W - JD_W){f_jd2[JD_W-1]}}, f_jd2}
                 - JD_BASE;

  // last active slot: count saturated to 1..TABLE_DEPTH, minus one
  always_comb begin
    if (cfg_count_r == '0) begin
      start_addr = '0;
    end else if (32'(cfg_count_r) >= TABLE_DEPTH) begin
      start_addr = AW'(TABLE_DEPTH - 1);
    end else begin
      start_addr = AW'(cfg_count_r - CFG_W'(1));
    end
  end

  // p0 -> p1: time minus entry start
  assign mjd_ext   = {{(DW - MJD_W){mjd_r[MJD_W-1]}}, mjd_r};
  assign start_ext = {{(DW - SW + 1){1'b0}}, rd_data.mjd, {F{1'b0}}};
  assign d_nxt     = mjd_ext - $signed(start_ext);

  // p1 -> p2: compare flags and the TAI side scaled to seconds; beyond the clamp
  // the sign alone decides, so the product is only used inside it
  assign utc_ge_nxt  = ~d_r[DW-1];
  assign day_ge_nxt  = d_r >= NEG_ONE_DAY;
  assign big_pos_nxt = d_r > CLAMP_POS;
  assign big_neg_nxt = d_r < CLAMP_NEG;
  assign prod_nxt    = $signed({{(PROD_W - CLAMP_W){d_r[CLAMP_W-1]}}, d_r[CLAMP_W-1:0]})
                     * $signed(PROD_W'(SEC_PER_DAY));

  // p2: entry's own offset in seconds fixed point
  assign rhs     = $signed({{(PROD_W - OFF_W){off2_r[OFF_W-1]}}, off2_r}) <<< F;
  assign tai_ge  = big_pos2_r | (~big_neg2_r & (prod_r >= rhs));
  assign at_zero = (idx2_r == '0);

  always_comb begin
    unique case (cmd_r)
      CMD_OFF_UTC: hit = utc_ge2_r | at_zero;
      CMD_OFF_TAI: hit = tai_ge | at_zero;
      CMD_DAY_UTC: hit = day_ge2_r | at_zero;
      CMD_LOAD:    hit = 1'b1;
      default:     hit = 1'b1;
    endcase
    hit = hit & v2_r;
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    ra_nxt         = ra_r;
    issue_done_nxt = issue_done_r;
    today_nxt      = today_r;
    next_nxt       = next_r;
    status_nxt     = status_r;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = AW'(f_index);
    mem_wdata      = '{mjd: f_mjd, off: f_off};
    mem_re         = 1'b0;
    mem_raddr      = ra_r;
    v0_nxt         = 1'b0;
    v1_nxt         = v0_r & ~hit;
    v2_nxt         = v1_r & ~hit;

    out_valid_nxt  = out_valid_r & ~out_tready;
    out_today_nxt  = out_today_r;
    out_next_nxt   = out_next_r;
    out_daylen_nxt = out_daylen_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      ST_INIT: begin
        if (!init_busy) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = f_cmd;
          today_nxt = '0;
          next_nxt  = '0;
          if (f_cmd == CMD_LOAD) begin
            // write now; slots beyond the table are dropped and flagged
            if (32'(f_index) < TABLE_DEPTH) begin
              mem_we     = 1'b1;
              status_nxt = STATUS_OK;
            end else begin
              status_nxt = STATUS_BAD_INDEX;
            end
            state_nxt = ST_OUT;
          end else begin
            status_nxt     = STATUS_OK;
            ra_nxt         = start_addr;
            issue_done_nxt = 1'b0;
            state_nxt      = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        // issue one read per cycle, newest slot first
        if (!issue_done_r) begin
          mem_re = 1'b1;
          v0_nxt = ~hit;
          ra_nxt = ra_r - AW'(1);
          if (ra_r == '0) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (hit) begin
          // first decision wins; flush the reads still in flight
          today_nxt = off2_r;
          state_nxt = ST_OUT;
          if (cmd_r == CMD_DAY_UTC) begin
            next_nxt = off2_r;
            if (!at_zero && !utc_ge2_r) begin
              // step falls at the end of this day: today uses the slot before
              ra_nxt    = idx2_r - AW'(1);
              state_nxt = ST_PREV;
            end
          end
        end
      end

      ST_PREV: begin
        mem_re    = 1'b1;
        state_nxt = ST_PREVW;
      end

      ST_PREVW: begin
        today_nxt = rd_data.off;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_today_nxt  = today_r;
          out_next_nxt   = next_r;
          out_status_nxt = status_r;
          if (cmd_r == CMD_DAY_UTC) begin
            out_daylen_nxt = DAYLEN_W'(SEC_PER_DAY)
                           - {{(DAYLEN_W - OFF_W){today_r[OFF_W-1]}}, today_r}
                           + {{(DAYLEN_W - OFF_W){next_r[OFF_W-1]}}, next_r};
          end else begin
            out_daylen_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- sequential
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cfg_count_r  <= CFG_W'(CFG_RESET);
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      issue_done_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      v0_r         <= v0_nxt;
      v1_r         <= v1_nxt;
      v2_r         <= v2_nxt;
      out_valid_r  <= out_valid_nxt;
      issue_done_r <= issue_done_nxt;
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ra_r         <= ra_nxt;
    today_r      <= today_nxt;
    next_r       <= next_nxt;
    status_r     <= status_nxt;
    if (in_tready && in_tvalid) begin
      mjd_r <= mjd_nxt;
    end
    idx0_r       <= ra_r;
    idx1_r       <= idx0_r;
    off1_r       <= rd_data.off;
    d_r          <= d_nxt;
    idx2_r       <= idx1_r;
    off2_r       <= off1_r;
    prod_r       <= prod_nxt;
    utc_ge2_r    <= utc_ge_nxt;
    day_ge2_r    <= day_ge_nxt;
    big_pos2_r   <= big_pos_nxt;
    big_neg2_r   <= big_neg_nxt;
    out_today_r  <= out_today_nxt;
    out_next_r   <= out_next_nxt;
    out_daylen_r <= out_daylen_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_daylen_r, out_next_r, out_today_r};

endmodule

/* rtl/lstl_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the leap-second step table lookup, bound to the top level.
// Depends on lstl_pkg.
module lstl_checker
  import lstl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  logic [DAYLEN_W-1:0] exp_daylen;

  assign exp_daylen = DAYLEN_W'(SEC_PER_DAY)
                    - {{(DAYLEN_W - OFF_W){out_tdata[7]}}, out_tdata[7:0]}
                    + {{(DAYLEN_W - OFF_W){out_tdata[15]}}, out_tdata[15:8]};

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // reset empties the output and blocks input, checked right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("handshake active right after reset");

  // one transaction at a time: no accept on the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // a rejected load reports nothing but its status
  a_bad_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[32:0] == '0)
    else $error("rejected load carries data");

  // day length agrees with the two offsets it is reported with
  a_daylen_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32:16] != '0 |-> out_tdata[32:16] == exp_daylen)
    else $error("day length inconsistent with offsets");

endmodule

bind leap_second_table_lookup lstl_checker u_lstl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
